>>> sv/iso8601_datetime_parser_unit_macros.svh
`ifndef ISO8601_DATETIME_PARSER_UNIT_MACROS_SVH
`define ISO8601_DATETIME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ISODT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ISODT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/isodt_pkg.sv
`timescale 1ns / 1ps

package isodt_pkg;

	// Magnitude of one parsed number
	localparam int unsigned MAG_W = 17;
	typedef logic [MAG_W-1:0] mag_t;

	// One parsed field: sign (set only for a nonzero negative value) and magnitude
	typedef struct packed {
		logic neg;
		mag_t mag;
	} field_t;

	localparam int unsigned NUM_FIELDS = 9;
	typedef field_t [NUM_FIELDS-1:0] field_arr_t;

	// Parser phases; the phase of a number is also its field slot
	typedef logic [3:0] phase_t;
	localparam phase_t PH_YEAR   = 4'd0;
	localparam phase_t PH_MONTH  = 4'd1;
	localparam phase_t PH_DAY    = 4'd2;
	localparam phase_t PH_HOUR   = 4'd3;
	localparam phase_t PH_MINUTE = 4'd4;
	localparam phase_t PH_SECOND = 4'd5;
	localparam phase_t PH_FRAC   = 4'd6;
	localparam phase_t PH_TZH    = 4'd7;
	localparam phase_t PH_TZM    = 4'd8;
	localparam phase_t PH_DONE   = 4'd9;

	// Limits
	localparam mag_t ACC_MAX    = 17'd99999;
	localparam mag_t TZ_CLAMP   = 17'd9999;
	localparam mag_t YEAR_MAX   = 17'd9999;
	localparam mag_t MONTH_MAX  = 17'd12;
	localparam mag_t HOUR_MAX   = 17'd23;
	localparam mag_t MINSEC_MAX = 17'd59;
	localparam mag_t FRAC_MAX   = 17'd999;

	// Zone offset in minutes
	typedef logic signed [20:0] tzoff_t;

	// Finished string handed from the parser to the checker
	typedef struct packed {
		logic       perr;
		field_arr_t fld;
	} snap_t;

	// Days in a month (1..12), February by leap flag
	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		if (m == 4'd2) begin
			d = leap ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			d = 5'd30;
		end else begin
			d = 5'd31;
		end
		return d;
	endfunction

endpackage

>>> sv/iso8601_datetime_parser_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake                    Word
// input    char_valid / char_ready      ch: one character, zero ends the string
// output   result_valid / result_ready  valid_res, year, month, day, hour,
//                                       minute, second, millisecond, tz_offset_minutes
//
// One character per cycle sustained while no stall holds the input; a terminator
// goes from the input register to the parser snapshot register, and its result
// then to the range check and offset register, where it is offered.
// arst_n clears the parser to the start of a new string and empties all stages.
// A stalled result holds only the check stage; characters keep flowing until another
// terminator reaches the parser while the snapshot already holds a finished string.

module iso8601_datetime_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  logic [7:0]         ch,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               valid_res,
	output logic [13:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [9:0]         millisecond,
	output logic signed [20:0] tz_offset_minutes
);

	logic             s1_v_q;
	logic [7:0]       ch_s1;
	logic             p_ready;
	logic             snap_valid;
	logic             snap_ready;
	isodt_pkg::snap_t snap;

	// Input register
	assign char_ready = !s1_v_q || p_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (char_ready) begin
			s1_v_q <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			ch_s1 <= ch;
		end
	end

	isodt_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (s1_v_q),
		.char_ready (p_ready),
		.ch         (ch_s1),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	isodt_check u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.snap_valid        (snap_valid),
		.snap_ready        (snap_ready),
		.snap              (snap),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.valid_res         (valid_res),
		.year              (year),
		.month             (month),
		.day               (day),
		.hour              (hour),
		.minute            (minute),
		.second            (second),
		.millisecond       (millisecond),
		.tz_offset_minutes (tz_offset_minutes)
	);

endmodule

>>> sv/isodt_parser.sv
`timescale 1ns / 1ps

module isodt_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  logic [7:0]        ch,
	output logic              snap_valid,
	input  logic              snap_ready,
	output isodt_pkg::snap_t  snap
);

	`include "iso8601_datetime_parser_unit_macros.svh"

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [2:0] CNT_SAT  = 3'd7;
	localparam logic [2:0] FRAC_LEN = 3'd3;

	// Parser state
	isodt_pkg::phase_t     phase_q, phase_d;
	isodt_pkg::mag_t       acc_q, acc_d;
	logic                  neg_q, neg_d;
	logic                  has_q, has_d;
	logic [2:0]            cnt_q, cnt_d;
	logic                  sign_q, sign_d;
	isodt_pkg::field_arr_t fld_q, fld_d;
	logic                  perr_q, perr_d;

	// Output snapshot
	logic                  snap_v_q;
	isodt_pkg::snap_t      snap_q;

	logic                  go;
	logic                  is_term;
	logic                  is_digit;
	logic                  is_ws;
	logic                  is_sign;
	logic                  active;
	logic                  step_ok;
	logic [2:0]            cnt_inc;
	logic [20:0]           acc_x;
	isodt_pkg::mag_t       acc_sat;
	logic [23:0]           scaled;
	isodt_pkg::mag_t       end_mag;
	logic                  end_neg;

	// Classify the character
	assign is_term  = (ch == CH_NUL);
	assign is_digit = (ch >= CH_0) && (ch <= CH_9);
	assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

	// A terminator needs a free snapshot slot
	assign char_ready = !is_term || !snap_v_q || snap_ready;
	assign go         = char_valid && char_ready;
	assign active     = !perr_q && (phase_q != isodt_pkg::PH_DONE);

	// Accumulate a digit with saturation
	assign acc_x   = {4'd0, acc_q} * 21'd10 + {17'd0, ch[3:0]};
	assign acc_sat = (acc_x > {4'd0, isodt_pkg::ACC_MAX}) ? isodt_pkg::ACC_MAX
	                                                      : acc_x[16:0];
	assign cnt_inc = (cnt_q != CNT_SAT) ? cnt_q + 3'd1 : cnt_q;

	// Scale a short fraction up to milliseconds
	always_comb begin
		case (cnt_q)
			3'd1:    scaled = {7'd0, acc_q} * 24'd100;
			3'd2:    scaled = {7'd0, acc_q} * 24'd10;
			default: scaled = {7'd0, acc_q};
		endcase
	end

	assign end_mag = (phase_q == isodt_pkg::PH_FRAC) ? scaled[16:0] : acc_q;
	assign end_neg = neg_q && (end_mag != '0);

	// Next parser state for one character
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		has_d   = has_q;
		cnt_d   = cnt_q;
		sign_d  = sign_q;
		fld_d   = fld_q;
		perr_d  = perr_q;
		step_ok = 1'b0;
		if (active) begin
			if (has_q && !is_digit) begin
				// number ends; judge the character as separator
				fld_d[phase_q] = '{neg: end_neg, mag: end_mag};
				acc_d  = '0;
				neg_d  = 1'b0;
				has_d  = 1'b0;
				cnt_d  = '0;
				sign_d = 1'b0;
				case (phase_q)
					isodt_pkg::PH_YEAR, isodt_pkg::PH_MONTH, isodt_pkg::PH_HOUR,
					isodt_pkg::PH_MINUTE, isodt_pkg::PH_TZH: begin
						if (is_term) begin
							perr_d = 1'b1;
						end else begin
							phase_d = phase_q + 4'd1;
						end
					end
					isodt_pkg::PH_DAY: begin
						if (ch == CH_T) begin
							phase_d = isodt_pkg::PH_HOUR;
						end else if (!is_term) begin
							perr_d = 1'b1;
						end
					end
					isodt_pkg::PH_SECOND, isodt_pkg::PH_FRAC: begin
						if ((phase_q == isodt_pkg::PH_SECOND) && (ch == CH_DOT)) begin
							phase_d = isodt_pkg::PH_FRAC;
						end else if (is_sign) begin
							phase_d = isodt_pkg::PH_TZH;
							sign_d  = 1'b1;
							neg_d   = (ch == CH_MINUS);
						end else if (ch == CH_Z) begin
							phase_d = isodt_pkg::PH_DONE;
						end else if (!is_term) begin
							perr_d = 1'b1;
						end
					end
					default: begin
						phase_d = isodt_pkg::PH_DONE;
					end
				endcase
			end else begin
				if (is_digit) begin
					has_d   = 1'b1;
					acc_d   = acc_sat;
					step_ok = 1'b1;
				end else if (!sign_q && is_ws) begin
					step_ok = 1'b1;
				end else if (!sign_q && is_sign) begin
					sign_d  = 1'b1;
					neg_d   = (ch == CH_MINUS);
					step_ok = 1'b1;
				end else begin
					perr_d = 1'b1;
				end
				if (step_ok) begin
					cnt_d = cnt_inc;
					if ((phase_q == isodt_pkg::PH_FRAC) && (cnt_inc > FRAC_LEN)) begin
						perr_d = 1'b1;
					end
				end
			end
		end
	end

	// Advance parser state; a terminator drops it back to the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= isodt_pkg::PH_YEAR;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			has_q   <= 1'b0;
			cnt_q   <= '0;
			sign_q  <= 1'b0;
			fld_q   <= '0;
			perr_q  <= 1'b0;
		end else if (go) begin
			if (is_term) begin
				phase_q <= isodt_pkg::PH_YEAR;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				has_q   <= 1'b0;
				cnt_q   <= '0;
				sign_q  <= 1'b0;
				fld_q   <= '0;
				perr_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				has_q   <= has_d;
				cnt_q   <= cnt_d;
				sign_q  <= sign_d;
				fld_q   <= fld_d;
				perr_q  <= perr_d;
			end
		end
	end

	// Hold the finished string until the checker takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_q <= 1'b0;
		end else if (go && is_term) begin
			snap_v_q <= 1'b1;
		end else if (snap_ready) begin
			snap_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_term) begin
			snap_q <= '{perr: perr_d, fld: fld_d};
		end
	end

	assign snap_valid = snap_v_q;
	assign snap       = snap_q;

	`ISODT_ASSERT_NEXT(a_term_restarts, clk, arst_n, go && is_term,
		phase_q == isodt_pkg::PH_YEAR && !perr_q && !has_q && fld_q == '0,
		"parser did not restart after terminator")
	`ISODT_ASSERT_NOW(a_acc_capped, clk, arst_n, 1'b1, acc_q <= isodt_pkg::ACC_MAX,
		"accumulator above saturation limit")
	`ISODT_ASSERT_NOW(a_frac_short, clk, arst_n, phase_q == isodt_pkg::PH_FRAC && !perr_q,
		cnt_q <= FRAC_LEN, "long fraction without error")
	`ISODT_ASSERT_NEXT(a_snap_hold, clk, arst_n, snap_valid && !snap_ready,
		snap_valid && $stable(snap), "stalled snapshot changed")

endmodule

>>> sv/isodt_check.sv
`timescale 1ns / 1ps

module isodt_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              snap_valid,
	output logic              snap_ready,
	input  isodt_pkg::snap_t  snap,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              valid_res,
	output logic [13:0]       year,
	output logic [3:0]        month,
	output logic [4:0]        day,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second,
	output logic [9:0]        millisecond,
	output logic signed [20:0] tz_offset_minutes
);

	isodt_pkg::field_t fy, fmo, fd, fh, fmi, fs, ff, fzh, fzm;
	logic [26:0]       prod;
	logic              div100;
	logic              leap;
	logic [4:0]        dim;
	logic              year_ok, month_ok, day_ok, hour_ok, min_ok, sec_ok, frac_ok;
	logic              ok;
	logic [13:0]       thc, tmc;
	isodt_pkg::tzoff_t th_mag, tm_mag, th_s, tm_s, th60, off;
	logic              take;

	logic              res_v_q;
	logic              valid_res_q;
	logic [13:0]       year_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;
	logic [9:0]        ms_q;
	isodt_pkg::tzoff_t off_q;

	assign fy  = snap.fld[isodt_pkg::PH_YEAR];
	assign fmo = snap.fld[isodt_pkg::PH_MONTH];
	assign fd  = snap.fld[isodt_pkg::PH_DAY];
	assign fh  = snap.fld[isodt_pkg::PH_HOUR];
	assign fmi = snap.fld[isodt_pkg::PH_MINUTE];
	assign fs  = snap.fld[isodt_pkg::PH_SECOND];
	assign ff  = snap.fld[isodt_pkg::PH_FRAC];
	assign fzh = snap.fld[isodt_pkg::PH_TZH];
	assign fzm = snap.fld[isodt_pkg::PH_TZM];

	// Leap year: y*5243 >> 19 is y/100 for y below 43690; a zero remainder
	// leaves a low part under 5243
	assign prod   = fy.mag[13:0] * 13'd5243;
	assign div100 = (prod[18:0] < 19'd5243);
	assign leap   = (fy.mag[1:0] == 2'b00) && (!div100 || (prod[20:19] == 2'b00));
	assign dim    = isodt_pkg::days_in_month(fmo.mag[3:0], leap);

	// Range checks
	assign year_ok  = !fy.neg && (fy.mag != '0) && (fy.mag <= isodt_pkg::YEAR_MAX);
	assign month_ok = !fmo.neg && (fmo.mag != '0) && (fmo.mag <= isodt_pkg::MONTH_MAX);
	assign day_ok   = !fd.neg && (fd.mag != '0) && (fd.mag <= {12'd0, dim});
	assign hour_ok  = !fh.neg && (fh.mag <= isodt_pkg::HOUR_MAX);
	assign min_ok   = !fmi.neg && (fmi.mag <= isodt_pkg::MINSEC_MAX);
	assign sec_ok   = !fs.neg && (fs.mag <= isodt_pkg::MINSEC_MAX);
	assign frac_ok  = !ff.neg && (ff.mag <= isodt_pkg::FRAC_MAX);
	assign ok = !snap.perr && year_ok && month_ok && day_ok && hour_ok && min_ok &&
	            sec_ok && frac_ok;

	// Zone offset: clamp both parts, hour*60 then add or subtract minutes
	assign thc    = (fzh.mag > isodt_pkg::TZ_CLAMP) ? isodt_pkg::TZ_CLAMP[13:0] : fzh.mag[13:0];
	assign tmc    = (fzm.mag > isodt_pkg::TZ_CLAMP) ? isodt_pkg::TZ_CLAMP[13:0] : fzm.mag[13:0];
	assign th_mag = {7'd0, thc};
	assign tm_mag = {7'd0, tmc};
	assign th_s   = fzh.neg ? -th_mag : th_mag;
	assign tm_s   = fzm.neg ? -tm_mag : tm_mag;
	assign th60   = (th_s <<< 6) - (th_s <<< 2);
	assign off    = fzh.neg ? (th60 - tm_s) : (th60 + tm_s);

	// Result register
	assign snap_ready = !res_v_q || result_ready;
	assign take       = snap_valid && snap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (snap_ready) begin
			res_v_q <= snap_valid;
		end
	end

	// Zero every field of a failed parse
	always_ff @(posedge clk) begin
		if (take) begin
			valid_res_q <= ok;
			year_q      <= ok ? fy.mag[13:0] : '0;
			month_q     <= ok ? fmo.mag[3:0] : '0;
			day_q       <= ok ? fd.mag[4:0] : '0;
			hour_q      <= ok ? fh.mag[4:0] : '0;
			minute_q    <= ok ? fmi.mag[5:0] : '0;
			second_q    <= ok ? fs.mag[5:0] : '0;
			ms_q        <= ok ? ff.mag[9:0] : '0;
			off_q       <= ok ? off : '0;
		end
	end

	assign result_valid      = res_v_q;
	assign valid_res         = valid_res_q;
	assign year              = year_q;
	assign month             = month_q;
	assign day               = day_q;
	assign hour              = hour_q;
	assign minute            = minute_q;
	assign second            = second_q;
	assign millisecond       = ms_q;
	assign tz_offset_minutes = off_q;

endmodule
